FILE: rtl/rgb_to_nv12_converter_assert.svh
// ----------------------------------------------------------------------------
// RGB to NV12 converter assertion macros
// Shared concurrent assertion forms; each expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef RGB_TO_NV12_CONVERTER_ASSERT_SVH
`define RGB_TO_NV12_CONVERTER_ASSERT_SVH

// same-cycle implication
`define RGBNV_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RGBNV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/rgbnv_pkg.sv
// ----------------------------------------------------------------------------
// RGB to NV12 converter package
// Sizes, coefficients, register indexes and shared types of the converter.
// ----------------------------------------------------------------------------
package rgbnv_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;

  localparam int DIM_W     = 12;                        // frame_width / frame_height
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int ROW_W     = $clog2(MAX_HEIGHT);
  localparam int LSTORE_DEPTH = MAX_WIDTH / 2;
  localparam int LSTORE_AW = $clog2(LSTORE_DEPTH);
  localparam int PLANE_W   = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int LOFF_W    = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int CIDX_W    = $clog2(MAX_WIDTH * MAX_HEIGHT / 2);
  localparam int OFF_W     = 23;                        // byte_offset field
  localparam int SUM_W     = 9;                         // one pair sum
  localparam int PROD_W    = 16;

  // queue between front and back; depth is a power of two
  localparam int Q_DEPTH = 8;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = CFG_IDX_W'(1);

  localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(1280);
  localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(720);
  localparam logic [DIM_W-1:0] DIM_MIN      = DIM_W'(2);
  localparam logic [DIM_W-1:0] WIDTH_LIM    = DIM_W'(MAX_WIDTH & ~1);
  localparam logic [DIM_W-1:0] HEIGHT_LIM   = DIM_W'(MAX_HEIGHT & ~1);

  localparam logic KIND_LUMA   = 1'b0;
  localparam logic KIND_CHROMA = 1'b1;

  // BT.601 limited range, 8-bit coefficients
  localparam logic [7:0] K_Y_R   = 8'd66;
  localparam logic [7:0] K_Y_G   = 8'd129;
  localparam logic [7:0] K_Y_B   = 8'd25;
  localparam logic [7:0] K_CB_R  = 8'd38;
  localparam logic [7:0] K_CB_G  = 8'd74;
  localparam logic [7:0] K_HI    = 8'd112;
  localparam logic [7:0] K_CR_G  = 8'd94;
  localparam logic [7:0] K_CR_B  = 8'd18;
  localparam logic [7:0] ROUND   = 8'd128;
  localparam logic [7:0] Y_OFS   = 8'd16;
  // 128 offset shifted up by 8, plus rounding; keeps chroma sums positive
  localparam logic [PROD_W-1:0] CHROMA_BIAS = PROD_W'(128 * 256 + 128);

  typedef enum logic {
    BK_PASS,
    BK_CHROMA
  } bk_state_t;

  // one classified and converted pixel
  typedef struct packed {
    logic [7:0]           luma;
    logic [7:0]           cb;
    logic [7:0]           cr;
    logic [LOFF_W-1:0]    luma_off;
    logic [OFF_W-1:0]     chroma_off;
    logic [LSTORE_AW-1:0] idx;
    logic                 odd_col;
    logic                 odd_row;
    logic                 last_pixel;
  } pix_item_t;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] raw,
                                               input logic [DIM_W-1:0] lim);
    logic [DIM_W-1:0] v;
    v = {raw[DIM_W-1:1], 1'b0};
    if (v < DIM_MIN) v = DIM_MIN;
    if (v > lim) v = lim;
    return v;
  endfunction

endpackage

FILE: rtl/rgbnv_if.sv
// ----------------------------------------------------------------------------
// RGB to NV12 converter channel interfaces
// Pixel input, result output and register write channels.
// ----------------------------------------------------------------------------
interface rgbnv_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] blue;
  logic [7:0] green;
  logic [7:0] red;

  modport source (output valid, output blue, output green, output red, input ready);
  modport sink   (input valid, input blue, input green, input red, output ready);
endinterface

interface rgbnv_res_if import rgbnv_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             kind;
  logic [7:0]       luma;
  logic [7:0]       cb_value;
  logic [7:0]       cr_value;
  logic [OFF_W-1:0] byte_offset;
  logic             last_of_run;
  logic             frame_done;

  modport source (output valid, output kind, output luma, output cb_value,
                  output cr_value, output byte_offset, output last_of_run,
                  output frame_done, input ready);
  modport sink   (input valid, input kind, input luma, input cb_value,
                  input cr_value, input byte_offset, input last_of_run,
                  input frame_done, output ready);
endinterface

interface rgbnv_cfg_if import rgbnv_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DIM_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/rgb_to_nv12_converter.sv
// Path: the luma result of an accepted pixel passes stages s0, s1 and s2, the queue and
// the output register; the chroma pair result of the same pixel follows it directly.
// Throughput: one pixel per cycle in while the queue has room; the single output register
// gives one result per cycle while the sink is ready, so a 2x2 block gives five results.
// Reset: synchronous, active low; 1280x720 frame, position zero; line store not cleared.
// ----------------------------------------------------------------------------
// RGB to NV12 converter
// Converts a raster stream of BGR pixels to NV12 luma and interleaved chroma words.
// ----------------------------------------------------------------------------
module rgb_to_nv12_converter import rgbnv_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  rgbnv_pix_if.sink    in_ch,
  rgbnv_res_if.source  out_ch,
  rgbnv_cfg_if.sink    cfg_ch
);

  logic               push_valid;
  pix_item_t          push_item;
  logic               head_valid;
  pix_item_t          head_item;
  logic               pop;
  logic [Q_CNT_W-1:0] q_count;

  rgbnv_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg_ch     (cfg_ch),
    .q_count    (q_count),
    .push_valid (push_valid),
    .push_item  (push_item)
  );

  rgbnv_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_item  (push_item),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item),
    .count      (q_count)
  );

  rgbnv_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (head_valid),
    .q_item  (head_item),
    .q_pop   (pop),
    .out_ch  (out_ch)
  );

endmodule

FILE: rtl/rgbnv_fifo.sv
// ----------------------------------------------------------------------------
// RGB to NV12 converter item queue
// Short register queue that decouples the front pipeline from the back end.
// ----------------------------------------------------------------------------
module rgbnv_fifo import rgbnv_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  input  pix_item_t          push_item,
  input  logic               pop,
  output logic               head_valid,
  output pix_item_t          head_item,
  output logic [Q_CNT_W-1:0] count
);

  pix_item_t          mem_r [Q_DEPTH];
  logic [Q_AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = push_valid ? wr_ptr_r + Q_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + Q_AW'(1) : rd_ptr_r;
    count_nxt  = count_r + Q_CNT_W'(push_valid) - Q_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_valid) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  assign head_valid = (count_r != '0);
  assign head_item  = mem_r[rd_ptr_r];
  assign count      = count_r;

endmodule

FILE: rtl/rgbnv_front.sv
// ----------------------------------------------------------------------------
// RGB to NV12 converter front end
// Holds the frame registers, accepts pixels, tracks position and offsets,
// and converts RGB to YCbCr in a three-stage pipeline feeding the queue.
// ----------------------------------------------------------------------------
module rgbnv_front import rgbnv_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  rgbnv_pix_if.sink          in_ch,
  rgbnv_cfg_if.sink          cfg_ch,
  input  logic [Q_CNT_W-1:0] q_count,
  output logic               push_valid,
  output pix_item_t          push_item
);

  typedef struct packed {
    logic [PROD_W-1:0] yr;
    logic [PROD_W-1:0] yg;
    logic [PROD_W-1:0] yb;
    logic [PROD_W-1:0] cbr;
    logic [PROD_W-1:0] cbg;
    logic [PROD_W-1:0] cbb;
    logic [PROD_W-1:0] crr;
    logic [PROD_W-1:0] crg;
    logic [PROD_W-1:0] crb;
  } prod_t;

  function automatic logic [PROD_W-1:0] mul_k(input logic [7:0] c, input logic [7:0] k);
    return PROD_W'(c) * PROD_W'(k);
  endfunction

  logic [DIM_W-1:0]   eff_w_r, eff_h_r;
  logic [PLANE_W-1:0] plane_r;

  logic [COL_W-1:0]   col_r, col_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [LOFF_W-1:0]  loff_r, loff_nxt;
  logic [CIDX_W-1:0]  ccnt_r, ccnt_nxt;

  logic               cfg_wr, restart, in_fire;
  logic               last_col, last_row, last_pixel, chroma_emit;
  logic [Q_CNT_W:0]   busy;

  logic               s0_v_r, s1_v_r, s2_v_r;
  logic [7:0]         s0_blue_r, s0_green_r, s0_red_r;
  pix_item_t          s0_item_r, s1_item_r, s2_item_r;
  pix_item_t          s0_item_nxt, s1_item_nxt, s2_item_nxt;
  prod_t              s1_prod_r;
  logic [PROD_W-1:0]  y_sum, cb_sum, cr_sum;

  // register writes
  assign cfg_ch.ready = 1'b1;
  assign cfg_wr       = cfg_ch.valid && cfg_ch.ready;
  assign restart      = cfg_wr && (cfg_ch.index inside {CFG_FRAME_WIDTH, CFG_FRAME_HEIGHT});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eff_w_r <= eff_dim(WIDTH_RESET, WIDTH_LIM);
      eff_h_r <= eff_dim(HEIGHT_RESET, HEIGHT_LIM);
    end else if (cfg_wr) begin
      if (cfg_ch.index == CFG_FRAME_WIDTH) begin
        eff_w_r <= eff_dim(cfg_ch.data, WIDTH_LIM);
      end
      if (cfg_ch.index == CFG_FRAME_HEIGHT) begin
        eff_h_r <= eff_dim(cfg_ch.data, HEIGHT_LIM);
      end
    end
  end

  // luma plane size, the base of the chroma plane
  always_ff @(posedge clk) begin
    plane_r <= PLANE_W'(eff_w_r) * PLANE_W'(eff_h_r);
  end

  // take a pixel only when the queue has room for everything in flight
  assign busy = (Q_CNT_W+1)'(q_count) + (Q_CNT_W+1)'(s0_v_r) + (Q_CNT_W+1)'(s1_v_r)
              + (Q_CNT_W+1)'(s2_v_r);
  assign in_ch.ready = (busy < (Q_CNT_W+1)'(Q_DEPTH));
  assign in_fire     = in_ch.valid && in_ch.ready;

  // classify the pixel at the current position
  always_comb begin
    last_col    = (DIM_W'(col_r) == eff_w_r - DIM_W'(1));
    last_row    = (DIM_W'(row_r) == eff_h_r - DIM_W'(1));
    last_pixel  = last_col && last_row;
    chroma_emit = col_r[0] && row_r[0];
  end

  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    loff_nxt = loff_r;
    ccnt_nxt = ccnt_r;
    if (restart) begin
      col_nxt  = '0;
      row_nxt  = '0;
      loff_nxt = '0;
      ccnt_nxt = '0;
    end else if (in_fire) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
      loff_nxt = last_pixel ? '0 : loff_r + LOFF_W'(1);
      if (last_pixel) begin
        ccnt_nxt = '0;
      end else if (chroma_emit) begin
        ccnt_nxt = ccnt_r + CIDX_W'(2);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      loff_r <= '0;
      ccnt_r <= '0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      loff_r <= loff_nxt;
      ccnt_r <= ccnt_nxt;
    end
  end

  // stage payloads
  always_comb begin
    s0_item_nxt            = '0;
    s0_item_nxt.luma_off   = loff_r;
    s0_item_nxt.chroma_off = OFF_W'(ccnt_r);
    s0_item_nxt.idx        = col_r[COL_W-1:1];
    s0_item_nxt.odd_col    = col_r[0];
    s0_item_nxt.odd_row    = row_r[0];
    s0_item_nxt.last_pixel = last_pixel;

    s1_item_nxt            = s0_item_r;
    s1_item_nxt.chroma_off = OFF_W'(plane_r) + s0_item_r.chroma_off;

    y_sum  = s1_prod_r.yr + s1_prod_r.yg + s1_prod_r.yb + PROD_W'(ROUND);
    cb_sum = s1_prod_r.cbb + CHROMA_BIAS - s1_prod_r.cbr - s1_prod_r.cbg;
    cr_sum = s1_prod_r.crr + CHROMA_BIAS - s1_prod_r.crg - s1_prod_r.crb;

    s2_item_nxt      = s1_item_r;
    s2_item_nxt.luma = y_sum[PROD_W-1:8] + Y_OFS;
    s2_item_nxt.cb   = cb_sum[PROD_W-1:8];
    s2_item_nxt.cr   = cr_sum[PROD_W-1:8];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s0_v_r <= in_fire;
      s1_v_r <= s0_v_r;
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s0_blue_r  <= in_ch.blue;
    s0_green_r <= in_ch.green;
    s0_red_r   <= in_ch.red;
    s0_item_r  <= s0_item_nxt;

    s1_prod_r.yr  <= mul_k(s0_red_r, K_Y_R);
    s1_prod_r.yg  <= mul_k(s0_green_r, K_Y_G);
    s1_prod_r.yb  <= mul_k(s0_blue_r, K_Y_B);
    s1_prod_r.cbr <= mul_k(s0_red_r, K_CB_R);
    s1_prod_r.cbg <= mul_k(s0_green_r, K_CB_G);
    s1_prod_r.cbb <= mul_k(s0_blue_r, K_HI);
    s1_prod_r.crr <= mul_k(s0_red_r, K_HI);
    s1_prod_r.crg <= mul_k(s0_green_r, K_CR_G);
    s1_prod_r.crb <= mul_k(s0_blue_r, K_CR_B);
    s1_item_r     <= s1_item_nxt;

    s2_item_r <= s2_item_nxt;
  end

  assign push_valid = s2_v_r;
  assign push_item  = s2_item_r;

endmodule

FILE: rtl/rgbnv_back.sv
// ----------------------------------------------------------------------------
// RGB to NV12 converter back end
// Accumulates chroma pair sums through the line store and emits the luma
// result of every pixel and the Cb/Cr pair result of each 2x2 block.
// ----------------------------------------------------------------------------
`include "rgb_to_nv12_converter_assert.svh"

module rgbnv_back import rgbnv_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         q_valid,
  input  pix_item_t    q_item,
  output logic         q_pop,
  rgbnv_res_if.source  out_ch
);

  typedef struct packed {
    logic             kind;
    logic [7:0]       luma;
    logic [7:0]       cb_value;
    logic [7:0]       cr_value;
    logic [OFF_W-1:0] byte_offset;
    logic             last_of_run;
    logic             frame_done;
  } res_t;

  logic [2*SUM_W-1:0] line_mem [LSTORE_DEPTH];
  logic [2*SUM_W-1:0] rd_r;

  bk_state_t          state_r, state_nxt;
  logic               out_v_r;
  res_t               out_res_r;
  res_t               ch_res_r;
  logic [SUM_W-1:0]   pend_cb_r, pend_cr_r;

  logic               load_ok, ld_luma, ld_chroma, q_emit;
  logic [SUM_W-1:0]   pair_cb, pair_cr;
  logic [SUM_W:0]     blk_cb, blk_cr;
  res_t               luma_res, chroma_res;

  assign load_ok = !out_v_r || out_ch.ready;
  assign q_emit  = q_item.odd_col && q_item.odd_row;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_PASS: begin
        if (load_ok && q_valid && q_emit) state_nxt = BK_CHROMA;
      end
      BK_CHROMA: begin
        if (load_ok) state_nxt = BK_PASS;
      end
      default: state_nxt = BK_PASS;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    q_pop     = 1'b0;
    ld_chroma = 1'b0;
    case (state_r)
      BK_PASS:   q_pop     = load_ok && q_valid;
      BK_CHROMA: ld_chroma = load_ok;
      default: begin
        q_pop     = 1'b0;
        ld_chroma = 1'b0;
      end
    endcase
  end
  assign ld_luma = q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_PASS;
    end else begin
      state_r <= state_nxt;
    end
  end

  // pair and block sums
  always_comb begin
    pair_cb = pend_cb_r + SUM_W'(q_item.cb);
    pair_cr = pend_cr_r + SUM_W'(q_item.cr);
    blk_cb  = (SUM_W+1)'(pair_cb) + (SUM_W+1)'(rd_r[SUM_W-1:0]);
    blk_cr  = (SUM_W+1)'(pair_cr) + (SUM_W+1)'(rd_r[2*SUM_W-1:SUM_W]);

    luma_res             = '0;
    luma_res.kind        = KIND_LUMA;
    luma_res.luma        = q_item.luma;
    luma_res.byte_offset = OFF_W'(q_item.luma_off);
    luma_res.last_of_run = !q_emit;
    luma_res.frame_done  = !q_emit && q_item.last_pixel;

    chroma_res             = '0;
    chroma_res.kind        = KIND_CHROMA;
    chroma_res.cb_value    = blk_cb[SUM_W:2];
    chroma_res.cr_value    = blk_cr[SUM_W:2];
    chroma_res.byte_offset = q_item.chroma_off;
    chroma_res.last_of_run = 1'b1;
    chroma_res.frame_done  = q_item.last_pixel;
  end

  // first pixel of a pair: hold its sums and fetch the row above
  always_ff @(posedge clk) begin
    if (q_pop && !q_item.odd_col) begin
      pend_cb_r <= SUM_W'(q_item.cb);
      pend_cr_r <= SUM_W'(q_item.cr);
      rd_r      <= line_mem[q_item.idx];
    end
  end

  // second pixel on an even row: store the pair sums
  always_ff @(posedge clk) begin
    if (q_pop && q_item.odd_col && !q_item.odd_row) begin
      line_mem[q_item.idx] <= {pair_cr, pair_cb};
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_emit) begin
      ch_res_r <= chroma_res;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (ld_chroma || ld_luma) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_chroma) begin
      out_res_r <= ch_res_r;
    end else if (ld_luma) begin
      out_res_r <= luma_res;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.kind        = out_res_r.kind;
  assign out_ch.luma        = out_res_r.luma;
  assign out_ch.cb_value    = out_res_r.cb_value;
  assign out_ch.cr_value    = out_res_r.cr_value;
  assign out_ch.byte_offset = out_res_r.byte_offset;
  assign out_ch.last_of_run = out_res_r.last_of_run;
  assign out_ch.frame_done  = out_res_r.frame_done;

  `RGBNV_ASSERT_NEXT(a_chroma_follows_pop, q_pop && q_emit, state_r == BK_CHROMA, "chroma result not scheduled after its pixel")
  `RGBNV_ASSERT_NEXT(a_chroma_loaded, ld_chroma, out_v_r && out_res_r.kind == KIND_CHROMA && out_res_r.last_of_run, "chroma slot did not load a closing chroma result")
  `RGBNV_ASSERT_SAME(a_open_run_pending, out_v_r && out_res_r.kind == KIND_LUMA && !out_res_r.last_of_run, state_r == BK_CHROMA, "open luma run without pending chroma")

endmodule

FILE: verif/tb_rgb_to_nv12_converter.sv
// ----------------------------------------------------------------------------
// RGB to NV12 converter testbench
// Streams raster pixels under a range of frame sizes, predicts every luma and
// chroma word, and checks the result stream word by word against it.
// ----------------------------------------------------------------------------
module tb_rgb_to_nv12_converter import rgbnv_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_PIXELS    = 1350;
  localparam int IDLE_LIMIT       = 2000;
  localparam int TAIL_CYCLES      = 16;
  localparam int SHOWN_MISMATCHES = 100;

  typedef struct packed {
    logic             kind;
    logic [7:0]       luma;
    logic [7:0]       cb;
    logic [7:0]       cr;
    logic [OFF_W-1:0] offset;
    logic             last;
    logic             done;
  } nv12_word_t;

  typedef enum logic {
    ROW_PIXEL,
    ROW_REG
  } row_kind_t;

  typedef struct {
    row_kind_t            what;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [DIM_W-1:0]     reg_val;
    logic [7:0]           b;
    logic [7:0]           g;
    logic [7:0]           r;
    bit                   typed;
    nv12_word_t           word;
  } stim_row_t;

  typedef enum int {
    SINK_FREE,
    SINK_MOSTLY,
    SINK_SPARSE,
    SINK_PATTERN
  } sink_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  rgbnv_pix_if pix_bus ();
  rgbnv_res_if nv12_bus ();
  rgbnv_cfg_if reg_bus ();

  rgb_to_nv12_converter DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (pix_bus),
    .out_ch (nv12_bus),
    .cfg_ch (reg_bus)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // conversion state: registers, raster position, pair sums, line of sums
  logic [DIM_W-1:0]     width_reg  = WIDTH_RESET;
  logic [DIM_W-1:0]     height_reg = HEIGHT_RESET;
  int unsigned          pos_col    = 0;
  int unsigned          pos_row    = 0;
  logic [2*SUM_W-1:0]   pair_sums  = '0;
  logic [2*SUM_W-1:0]   line_sums [LSTORE_DEPTH];
  nv12_word_t           nv12_expected [$];

  int  err_count     = 0;
  int  words_checked = 0;
  int  stalled       = 0;
  int  burst_left    = 0;
  int  gap_max       = 0;
  bit  reg_live      = 1'b0;

  function automatic int unsigned active_dim(input logic [DIM_W-1:0] raw,
                                             input logic [DIM_W-1:0] lim);
    int unsigned v;
    v = raw & ~32'd1;
    if (v < DIM_MIN) return DIM_MIN;
    return (v > lim) ? lim : v;
  endfunction

  function automatic void predict_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [DIM_W-1:0] val);
    case (idx)
      CFG_FRAME_WIDTH:  width_reg = val;
      CFG_FRAME_HEIGHT: height_reg = val;
      default: return;   // unused index: frame goes on
    endcase
    pos_col = 0;
    pos_row = 0;
    pair_sums = '0;
  endfunction

  function automatic void predict_pixel(input logic [7:0] b, g, r);
    int unsigned w, h, bi, gi, ri, y, cb, cr, scb, scr;
    bit last_px, pair_out;
    nv12_word_t word;
    w  = active_dim(width_reg, WIDTH_LIM);
    h  = active_dim(height_reg, HEIGHT_LIM);
    bi = b;
    gi = g;
    ri = r;
    y  = ((66 * ri + 129 * gi + 25 * bi + 128) >> 8) + 16;
    // bias of 128 << 8 plus rounding keeps both sums positive
    cb = ((112 * bi + 32896 - 38 * ri - 74 * gi) >> 8) & 8'hFF;
    cr = ((112 * ri + 32896 - 94 * gi - 18 * bi) >> 8) & 8'hFF;
    pair_out = pos_row[0] && pos_col[0];
    last_px  = (pos_row == h - 1) && (pos_col == w - 1);

    word = '0;
    word.kind   = KIND_LUMA;
    word.luma   = 8'(y);
    word.offset = OFF_W'(pos_row * w + pos_col);
    word.last   = !pair_out;
    word.done   = !pair_out && last_px;
    nv12_expected.push_back(word);

    if (!pos_col[0]) begin
      pair_sums = {SUM_W'(cr), SUM_W'(cb)};
    end else begin
      scb = pair_sums[SUM_W-1:0] + cb;
      scr = pair_sums[2*SUM_W-1:SUM_W] + cr;
      if (!pos_row[0]) begin
        line_sums[pos_col >> 1] = {SUM_W'(scr), SUM_W'(scb)};
      end else begin
        scb += line_sums[pos_col >> 1][SUM_W-1:0];
        scr += line_sums[pos_col >> 1][2*SUM_W-1:SUM_W];
        word = '0;
        word.kind   = KIND_CHROMA;
        word.cb     = 8'(scb >> 2);
        word.cr     = 8'(scr >> 2);
        word.offset = OFF_W'(w * h + (pos_row >> 1) * w + pos_col - 1);
        word.last   = 1'b1;
        word.done   = last_px;
        nv12_expected.push_back(word);
      end
    end

    if (pos_col + 1 >= w) begin
      pos_col = 0;
      pos_row = (pos_row + 1 >= h) ? 0 : pos_row + 1;
    end else begin
      pos_col++;
    end
  endfunction

  task automatic flag_mismatch(input string msg);
    err_count++;
    // keep the log bounded when everything goes wrong
    if (err_count <= SHOWN_MISMATCHES) $display("%0t ns  mismatch: %s", $time, msg);
  endtask

  task automatic compare_field(input string name, input logic [OFF_W-1:0] got,
                               input logic [OFF_W-1:0] want, input nv12_word_t ref_word);
    if (got !== want)
      flag_mismatch($sformatf("word %0d (kind %0d at %0d) %s got %0d want %0d",
                              words_checked, ref_word.kind, ref_word.offset, name, got,
                              want));
  endtask

  always @(posedge clk) begin : nv12_check
    nv12_word_t seen, want;
    if (rst_n && nv12_bus.valid && nv12_bus.ready) begin
      seen.kind   = nv12_bus.kind;
      seen.luma   = nv12_bus.luma;
      seen.cb     = nv12_bus.cb_value;
      seen.cr     = nv12_bus.cr_value;
      seen.offset = nv12_bus.byte_offset;
      seen.last   = nv12_bus.last_of_run;
      seen.done   = nv12_bus.frame_done;
      if (nv12_expected.size() == 0) begin
        flag_mismatch($sformatf("unexpected word kind %0d at %0d", seen.kind, seen.offset));
      end else begin
        want = nv12_expected.pop_front();
        compare_field("kind", seen.kind, want.kind, want);
        compare_field("luma", seen.luma, want.luma, want);
        compare_field("cb_value", seen.cb, want.cb, want);
        compare_field("cr_value", seen.cr, want.cr, want);
        compare_field("byte_offset", seen.offset, want.offset, want);
        compare_field("last_of_run", seen.last, want.last, want);
        compare_field("frame_done", seen.done, want.done, want);
      end
      words_checked++;
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (pix_bus.valid && pix_bus.ready) || (nv12_bus.valid && nv12_bus.ready) ||
        (reg_bus.valid && reg_bus.ready)) begin
      stalled <= 0;
    end else if (stalled >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stalled <= stalled + 1;
    end
  end

  // result side: changing stall modes, plus long hold-offs to fill the pipe
  initial begin : nv12_sink
    sink_mode_t  mode;
    int          mode_left, hold_left, taken;
    logic [15:0] pattern;
    bit          held;
    mode = SINK_FREE;
    mode_left = 0;
    hold_left = 0;
    taken = 0;
    held = 1'b0;
    pattern = 16'hB38E;
    nv12_bus.ready = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (nv12_bus.valid && nv12_bus.ready) taken++;
      if (hold_left == 0 && ((!held && taken >= 300) || $urandom_range(0, 3999) == 0)) begin
        hold_left = $urandom_range(200, 320);
        held = 1'b1;
      end
      if (hold_left != 0) begin
        nv12_bus.ready <= 1'b0;
        hold_left--;
      end else begin
        if (mode_left == 0) begin
          mode = sink_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(40, 300);
        end
        mode_left--;
        case (mode)
          SINK_FREE:   nv12_bus.ready <= 1'b1;
          SINK_MOSTLY: nv12_bus.ready <= ($urandom_range(0, 3) != 0);
          SINK_SPARSE: nv12_bus.ready <= ($urandom_range(0, 3) == 0);
          default: begin
            nv12_bus.ready <= pattern[0];
            pattern = {pattern[0], pattern[15:1]};
          end
        endcase
      end
      @(posedge clk);
    end
  end

  task automatic wait_drained();
    pix_bus.valid <= 1'b0;
    if (reg_live) begin
      reg_bus.valid <= 1'b0;
      reg_live = 1'b0;
    end
    do @(posedge clk); while (nv12_expected.size() != 0);
  endtask

  // leave valid up after the write so back-to-back writes need no gap
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
    reg_bus.valid <= 1'b1;
    reg_bus.index <= idx;
    reg_bus.data  <= val;
    do @(posedge clk); while (!reg_bus.ready);
    reg_live = 1'b1;
    predict_reg(idx, val);
  endtask

  task automatic send_pixel(input logic [7:0] b, g, r, input bit typed,
                            input nv12_word_t typed_word);
    int base;
    if (reg_live) begin
      reg_bus.valid <= 1'b0;
      reg_live = 1'b0;
    end
    if (gap_max != 0 && burst_left == 0) begin
      pix_bus.valid <= 1'b0;
      repeat ($urandom_range(1, gap_max)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 160)
                                               : $urandom_range(1, 20);
    end
    if (burst_left != 0) burst_left--;
    pix_bus.valid <= 1'b1;
    pix_bus.blue  <= b;
    pix_bus.green <= g;
    pix_bus.red   <= r;
    do @(posedge clk); while (!pix_bus.ready);
    base = nv12_expected.size();
    predict_pixel(b, g, r);
    if (typed) nv12_expected[base] = typed_word;
  endtask

  function automatic stim_row_t pixel_row(input logic [7:0] b, g, r);
    stim_row_t row;
    row.what = ROW_PIXEL;
    row.reg_idx = '0;
    row.reg_val = '0;
    row.b = b;
    row.g = g;
    row.r = r;
    row.typed = 1'b0;
    row.word = '0;
    return row;
  endfunction

  function automatic stim_row_t luma_row(input logic [7:0] b, g, r, y,
                                         input int unsigned off, input logic last);
    stim_row_t row;
    row = pixel_row(b, g, r);
    row.typed = 1'b1;
    row.word.kind = KIND_LUMA;
    row.word.luma = y;
    row.word.offset = OFF_W'(off);
    row.word.last = last;
    return row;
  endfunction

  function automatic stim_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [DIM_W-1:0] val);
    stim_row_t row;
    row = pixel_row(8'd0, 8'd0, 8'd0);
    row.what = ROW_REG;
    row.reg_idx = idx;
    row.reg_val = val;
    return row;
  endfunction

  function automatic logic [DIM_W-1:0] pick_dim();
    case ($urandom_range(0, 9))
      0:       return DIM_W'($urandom);              // saturates high about half the time
      1:       return DIM_W'($urandom_range(0, 1));  // below the minimum
      default: return DIM_W'($urandom_range(0, 24));
    endcase
  endfunction

  function automatic logic [7:0] channel_value();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  initial begin : stimulus
    stim_row_t   rows [$];
    int          sent, n_pix;
    int unsigned w, h;
    bit          wide_done;
    pix_bus.valid = 1'b0;
    pix_bus.blue  = '0;
    pix_bus.green = '0;
    pix_bus.red   = '0;
    reg_bus.valid = 1'b0;
    reg_bus.index = CFG_FRAME_WIDTH;
    reg_bus.data  = '0;
    sent = 0;
    wide_done = 1'b0;

    // reset frame size: primaries and the black and white extremes
    rows.push_back(luma_row(8'd0, 8'd0, 8'd0, 8'd16, 0, 1'b1));
    rows.push_back(luma_row(8'd255, 8'd255, 8'd255, 8'd235, 1, 1'b1));
    rows.push_back(luma_row(8'd0, 8'd0, 8'd255, 8'd82, 2, 1'b1));
    rows.push_back(luma_row(8'd0, 8'd255, 8'd0, 8'd144, 3, 1'b1));
    rows.push_back(luma_row(8'd255, 8'd0, 8'd0, 8'd41, 4, 1'b1));
    // 4x2 frame, odd height register value; blue block then red block, then wrap
    rows.push_back(reg_row(CFG_FRAME_WIDTH, 12'd4));
    rows.push_back(reg_row(CFG_FRAME_HEIGHT, 12'd3));
    rows.push_back(luma_row(8'd255, 8'd0, 8'd0, 8'd41, 0, 1'b1));
    rows.push_back(luma_row(8'd255, 8'd0, 8'd0, 8'd41, 1, 1'b1));
    rows.push_back(luma_row(8'd0, 8'd0, 8'd255, 8'd82, 2, 1'b1));
    rows.push_back(luma_row(8'd0, 8'd0, 8'd255, 8'd82, 3, 1'b1));
    rows.push_back(luma_row(8'd255, 8'd0, 8'd0, 8'd41, 4, 1'b1));
    rows.push_back(luma_row(8'd255, 8'd0, 8'd0, 8'd41, 5, 1'b0));
    rows.push_back(luma_row(8'd0, 8'd0, 8'd255, 8'd82, 6, 1'b1));
    rows.push_back(luma_row(8'd0, 8'd0, 8'd255, 8'd82, 7, 1'b0));
    rows.push_back(luma_row(8'd0, 8'd0, 8'd0, 8'd16, 0, 1'b1));
    // width clamps up to the minimum, height clamps down to the maximum
    rows.push_back(reg_row(CFG_FRAME_WIDTH, 12'd1));
    rows.push_back(reg_row(CFG_FRAME_HEIGHT, 12'hFFF));
    rows.push_back(pixel_row(8'd255, 8'd0, 8'd255));
    rows.push_back(pixel_row(8'd0, 8'd255, 8'd0));
    rows.push_back(pixel_row(8'd128, 8'd128, 8'd128));
    rows.push_back(pixel_row(8'd1, 8'd2, 8'd3));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    gap_max = 4;
    foreach (rows[i]) begin
      if (rows[i].what == ROW_REG) begin
        if (!reg_live) wait_drained();
        write_reg(rows[i].reg_idx, rows[i].reg_val);
      end else begin
        send_pixel(rows[i].b, rows[i].g, rows[i].r, rows[i].typed, rows[i].word);
      end
    end

    while (sent < RANDOM_PIXELS) begin
      wait_drained();
      if (!wide_done && sent >= RANDOM_PIXELS / 2) begin
        // widest frame: both registers clamp to the maximum
        write_reg(CFG_FRAME_WIDTH, 12'hFFF);
        write_reg(CFG_FRAME_HEIGHT, 12'd2049);
        wide_done = 1'b1;
        n_pix = $urandom_range(120, 240);
      end else begin
        case ($urandom_range(0, 5))
          0: write_reg(CFG_FRAME_WIDTH, pick_dim());
          1: write_reg(CFG_FRAME_HEIGHT, pick_dim());
          2: write_reg(CFG_IDX_W'($urandom_range(int'(CFG_FRAME_HEIGHT) + 1,
                                                 (1 << CFG_IDX_W) - 1)),
                       DIM_W'($urandom));
          default: begin
            write_reg(CFG_FRAME_WIDTH, pick_dim());
            write_reg(CFG_FRAME_HEIGHT, pick_dim());
          end
        endcase
        w = active_dim(width_reg, WIDTH_LIM);
        h = active_dim(height_reg, HEIGHT_LIM);
        n_pix = $urandom_range(6, 2 * w * h + 6);
        if (n_pix > 240) n_pix = $urandom_range(120, 240);
      end
      // stop at the pixel budget
      if (n_pix > RANDOM_PIXELS - sent) n_pix = RANDOM_PIXELS - sent;
      sent += n_pix;
      gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      repeat (n_pix) begin
        if ($urandom_range(0, 199) == 0) wait_drained();
        send_pixel(channel_value(), channel_value(), channel_value(), 1'b0, '0);
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
